// File: design/ptrib_pkg.sv
`timescale 1ns / 1ps

package ptrib_pkg;

  // Fixed-point formats
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned ANGLE_BITS    = 30;   // CORDIC angle accumulator, Q2.30
  localparam int unsigned PRESCALE_BITS = 24;
  localparam int unsigned CORDIC_STEPS  = 30;
  localparam int unsigned SQRT_STEPS    = 32;   // one result bit per cell

  localparam int unsigned CW = 62;              // CORDIC x/y width
  localparam int unsigned ZW = 34;              // CORDIC angle width
  localparam int unsigned ROUND_SHIFT = ANGLE_BITS - FRACTION_BITS;
  localparam int unsigned AW = ZW - ROUND_SHIFT;  // rounded angle width
  localparam int unsigned NW = 22;              // signed bin numerator
  localparam int unsigned QW = NW - 1;          // quotient bits, one per divide cell
  localparam int unsigned DW = 20;              // bin divisor (twice the step)

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] ROUND_HALF  = ZW'(2 ** (ROUND_SHIFT - 1));

  localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158, 34'sd67021686,
    34'sd33543515,  34'sd16775850,  34'sd8388437,   34'sd4194282,   34'sd2097149,
    34'sd1048575,   34'sd524287,    34'sd262143,    34'sd131071,    34'sd65535,
    34'sd32767,     34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
    34'sd1023,      34'sd511,       34'sd255,       34'sd127,       34'sd63,
    34'sd31,        34'sd15,        34'sd7,         34'sd3,         34'sd1
  };

  typedef enum logic [2:0] {
    CFG_VMIN  = 3'd0,
    CFG_VSTEP = 3'd1,
    CFG_HMIN  = 3'd2,
    CFG_HSTEP = 3'd3,
    CFG_RLOW  = 3'd4,
    CFG_RHIGH = 3'd5,
    CFG_ROWS  = 3'd6,
    CFG_COLS  = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OUTCOME_WRITTEN    = 2'd0,
    OUTCOME_NOT_FINITE = 2'd1,
    OUTCOME_OFF_GRID   = 2'd2,
    OUTCOME_RANGE      = 2'd3
  } outcome_e;

  typedef struct packed {
    logic [63:0] rad;    // radicand bits still to be consumed, MSB first
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;  // atan2(0, 0)
  } cordic_t;

  typedef struct packed {
    logic [QW-1:0] num;
    logic [DW-1:0] rem;
    logic [QW-1:0] q;
    logic          ok;    // step nonzero and numerator nonnegative
  } div_t;

  typedef struct packed {
    logic        write_cell;
    logic [17:0] cell_index;
    logic [31:0] range_value;
    logic [1:0]  outcome;
  } result_t;

  // Quadrant pre-rotation so that x >= 0
  function automatic cordic_t cordic_pre(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                         logic zero);
    cordic_t c;
    c.zero = zero;
    if (x < 0) begin
      if (y >= 0) begin
        c.x = y;
        c.y = -x;
        c.z = HALF_PI_Q30;
      end else begin
        c.x = -y;
        c.y = x;
        c.z = -HALF_PI_Q30;
      end
    end else begin
      c.x = x;
      c.y = y;
      c.z = '0;
    end
    return c;
  endfunction

  // Q2.30 to FRACTION_BITS, round half up
  function automatic logic signed [AW-1:0] angle_round(cordic_t c);
    logic signed [ZW-1:0] t;
    t = c.z + ROUND_HALF;
    return c.zero ? '0 : AW'(t >>> ROUND_SHIFT);
  endfunction

endpackage

// File: design/ptrib_if.sv
`timescale 1ns / 1ps

interface ptrib_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               point_finite;

  modport source(output valid, point_x, point_y, point_z, point_finite, input ready);
  modport sink(input valid, point_x, point_y, point_z, point_finite, output ready);
endinterface

interface ptrib_result_if;
  logic        valid;
  logic        ready;
  logic        write_cell;
  logic [17:0] cell_index;
  logic [31:0] range_value;
  logic [1:0]  outcome;

  modport source(output valid, write_cell, cell_index, range_value, outcome, input ready);
  modport sink(input valid, write_cell, cell_index, range_value, outcome, output ready);
endinterface

// File: design/ptrib_delay.sv
`timescale 1ns / 1ps

module ptrib_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

// File: design/ptrib_sqrt_cell.sv
`timescale 1ns / 1ps

module ptrib_sqrt_cell (
  input  logic              clk_i,
  input  logic              en_i,
  input  ptrib_pkg::sqrt_t  state_i,
  output ptrib_pkg::sqrt_t  state_o
);

  ptrib_pkg::sqrt_t state_d, state_q;
  logic [35:0] rem_sh;
  logic [35:0] trial;

  // one root bit: bring down two radicand bits, try root*4+1
  always_comb begin
    rem_sh  = {state_i.rem, state_i.rad[63:62]};
    trial   = {2'b00, state_i.root, 2'b01};
    state_d = state_i;
    state_d.rad = {state_i.rad[61:0], 2'b00};
    if (rem_sh >= trial) begin
      state_d.rem  = 34'(rem_sh - trial);
      state_d.root = {state_i.root[30:0], 1'b1};
    end else begin
      state_d.rem  = rem_sh[33:0];
      state_d.root = {state_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

// File: design/ptrib_cordic_cell.sv
`timescale 1ns / 1ps

module ptrib_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  ptrib_pkg::cordic_t state_i,
  output ptrib_pkg::cordic_t state_o
);

  localparam logic signed [ptrib_pkg::ZW-1:0] ANG = ptrib_pkg::ATAN_TAB[STEP];

  ptrib_pkg::cordic_t state_d, state_q;
  logic signed [ptrib_pkg::CW-1:0] dx, dy;

  // vectoring step: rotate toward y = 0
  always_comb begin
    dx = state_i.y >>> STEP;
    dy = state_i.x >>> STEP;
    state_d = state_i;
    if (state_i.y > 0) begin
      state_d.x = state_i.x + dx;
      state_d.y = state_i.y - dy;
      state_d.z = state_i.z + ANG;
    end else begin
      state_d.x = state_i.x - dx;
      state_d.y = state_i.y + dy;
      state_d.z = state_i.z - ANG;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

// File: design/ptrib_div_cell.sv
`timescale 1ns / 1ps

module ptrib_div_cell (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [ptrib_pkg::DW-1:0] divisor_i,
  input  ptrib_pkg::div_t         state_i,
  output ptrib_pkg::div_t         state_o
);

  ptrib_pkg::div_t state_d, state_q;
  logic [ptrib_pkg::DW:0] rem_sh;

  // restoring division, one quotient bit
  always_comb begin
    rem_sh  = {state_i.rem, state_i.num[ptrib_pkg::QW-1]};
    state_d = state_i;
    state_d.num = {state_i.num[ptrib_pkg::QW-2:0], 1'b0};
    if (rem_sh >= {1'b0, divisor_i}) begin
      state_d.rem = ptrib_pkg::DW'(rem_sh - {1'b0, divisor_i});
      state_d.q   = {state_i.q[ptrib_pkg::QW-2:0], 1'b1};
    end else begin
      state_d.rem = rem_sh[ptrib_pkg::DW-1:0];
      state_d.q   = {state_i.q[ptrib_pkg::QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

// File: design/point_to_range_image_binning.sv
`timescale 1ns / 1ps

// Spherical range-image binning of lidar points.
// point_i (valid/ready): one point per beat, x/y/z signed Q15.16 metres plus a
//   finite flag. result_o (valid/ready): one result beat per point, in order:
//   write_cell, cell_index = row * columns + column, range_value and outcome.
// cfg_we_i/cfg_idx_i/cfg_data_i: register write, taken at any edge with cfg_we_i
//   high; write only while no point is in flight.
// Pipeline: a point accepted on point_i is registered for input, squares, sum,
//   the square-root cells, vertical pre-rotation, the vertical CORDIC cells,
//   rounding, bin numerator, the bin-division cells and output, in that order.
// Throughput: one point per cycle while not stalled, every stage moving in lockstep.
// Stall: when result_o is held off, the output register plus one skid register
//   absorb the last beat, then the whole pipe freezes; point_i.ready is driven
//   from a flop (skid empty), so there is no combinational ready path.
// Reset: asynchronous, clears the valid line and the output/skid flags and
//   loads the default grid; no clearing pass, points are taken from the first
//   edge after reset is released.
module point_to_range_image_binning #(
  parameter int unsigned MAX_ROWS    = 128,
  parameter int unsigned MAX_COLUMNS = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ptrib_point_if.sink           point_i,
  ptrib_result_if.source        result_o,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [31:0]           cfg_data_i
);

  localparam int unsigned CS = ptrib_pkg::CORDIC_STEPS;
  localparam int unsigned SS = ptrib_pkg::SQRT_STEPS;
  localparam int unsigned QS = ptrib_pkg::QW;

  // stage numbers (edges after acceptance at which a value sits in a register)
  localparam int unsigned ST_IN    = 1;
  localparam int unsigned ST_SUM   = 3;
  localparam int unsigned ST_RANGE = ST_SUM + SS;
  localparam int unsigned ST_HANG  = 2 + CS + 1;
  localparam int unsigned ST_ANG   = ST_RANGE + 1 + CS + 1;
  localparam int unsigned ST_LAST  = ST_ANG + 1 + QS;

  // ---------------------------------------------------------------- config
  logic signed [18:0] vmin_q, hmin_q;
  logic [18:0]        vstep_q, hstep_q;
  logic [31:0]        rlow_q, rhigh_q;
  logic [7:0]         rows_q;
  logic [11:0]        cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmin_q  <= '0;
      vstep_q <= 19'd1144;
      hmin_q  <= -19'sd205887;
      hstep_q <= 19'd201;
      rlow_q  <= '0;
      rhigh_q <= 32'hFFFF_FFFF;
      rows_q  <= 8'd128;
      cols_q  <= 12'd2048;
    end else if (cfg_we_i) begin
      unique case (ptrib_pkg::cfg_idx_e'(cfg_idx_i))
        ptrib_pkg::CFG_VMIN:  vmin_q  <= cfg_data_i[18:0];
        ptrib_pkg::CFG_VSTEP: vstep_q <= cfg_data_i[18:0];
        ptrib_pkg::CFG_HMIN:  hmin_q  <= cfg_data_i[18:0];
        ptrib_pkg::CFG_HSTEP: hstep_q <= cfg_data_i[18:0];
        ptrib_pkg::CFG_RLOW:  rlow_q  <= cfg_data_i;
        ptrib_pkg::CFG_RHIGH: rhigh_q <= cfg_data_i;
        ptrib_pkg::CFG_ROWS:  rows_q  <= cfg_data_i[7:0];
        ptrib_pkg::CFG_COLS:  cols_q  <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  logic [7:0]  rows_cap;
  logic [11:0] cols_cap;
  assign rows_cap = (32'(rows_q) > MAX_ROWS) ? 8'(MAX_ROWS) : rows_q;
  assign cols_cap = (32'(cols_q) > MAX_COLUMNS) ? 12'(MAX_COLUMNS) : cols_q;

  // ---------------------------------------------------------------- flow
  logic adv;                      // whole pipe moves
  logic skid_v_q, skid_v_d;
  logic res_v_q, res_v_d;
  logic v_q [ST_LAST];            // valid per stage, v_q[k-1] is stage k

  assign adv           = !skid_v_q;
  assign point_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ST_LAST; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (adv) begin
      v_q[0] <= point_i.valid;
      for (int k = 1; k < ST_LAST; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage 1, 2, 3
  logic signed [31:0] x_q, y_q, z_q;
  logic               fin_q;
  logic signed [63:0] sqx, sqy, sqz;
  logic [62:0]        sqx_q, sqy_q, sqz_q;
  logic [63:0]        sum_q;
  ptrib_pkg::cordic_t hpre_q;

  assign sqx = x_q * x_q;
  assign sqy = y_q * y_q;
  assign sqz = z_q * z_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q    <= point_i.point_x;
      y_q    <= point_i.point_y;
      z_q    <= point_i.point_z;
      fin_q  <= point_i.point_finite;
      sqx_q  <= sqx[62:0];
      sqy_q  <= sqy[62:0];
      sqz_q  <= sqz[62:0];
      hpre_q <= ptrib_pkg::cordic_pre({{6{x_q[31]}}, x_q, 24'b0},
                                      {{6{y_q[31]}}, y_q, 24'b0},
                                      (x_q == '0) && (y_q == '0));
      sum_q  <= 64'(sqx_q) + 64'(sqy_q) + 64'(sqz_q);
    end
  end

  // ---------------------------------------------------------------- square root
  ptrib_pkg::sqrt_t sq_st [SS+1];
  assign sq_st[0] = '{rad: sum_q, rem: '0, root: '0};

  for (genvar k = 0; k < SS; k++) begin : g_sqrt
    ptrib_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (adv),
      .state_i (sq_st[k]),
      .state_o (sq_st[k+1])
    );
  end

  // ---------------------------------------------------------------- horizontal angle
  ptrib_pkg::cordic_t hc [CS+1];
  assign hc[0] = hpre_q;

  for (genvar k = 0; k < CS; k++) begin : g_hcordic
    ptrib_cordic_cell #(.STEP(k)) u_cell (
      .clk_i   (clk_i),
      .en_i    (adv),
      .state_i (hc[k]),
      .state_o (hc[k+1])
    );
  end

  logic signed [ptrib_pkg::AW-1:0] hang_q, hang_d;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hang_q <= ptrib_pkg::angle_round(hc[CS]);
    end
  end

  // hang_a_q adds the last register, so it lines up with vang_q
  ptrib_delay #(.WIDTH(ptrib_pkg::AW), .DEPTH(ST_ANG - ST_HANG - 1)) u_hang_dly (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (hang_q),
    .q_o   (hang_d)
  );

  // ---------------------------------------------------------------- vertical angle
  logic signed [31:0] z_d;
  logic [31:0]        range_d;
  logic               fin_d;

  ptrib_delay #(.WIDTH(32), .DEPTH(ST_RANGE - ST_IN)) u_z_dly (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (z_q),
    .q_o   (z_d)
  );

  ptrib_delay #(.WIDTH(32), .DEPTH(ST_LAST - ST_RANGE)) u_range_dly (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (sq_st[SS].root),
    .q_o   (range_d)
  );

  ptrib_delay #(.WIDTH(1), .DEPTH(ST_LAST - ST_IN)) u_fin_dly (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (fin_q),
    .q_o   (fin_d)
  );

  ptrib_pkg::cordic_t vc [CS+1];

  // range >= 0, so the pre-rotation keeps the vector where it is
  always_ff @(posedge clk_i) begin
    if (adv) begin
      vc[0] <= ptrib_pkg::cordic_pre({6'b0, sq_st[SS].root, 24'b0},
                                     {{6{z_d[31]}}, z_d, 24'b0},
                                     (sq_st[SS].root == '0) && (z_d == '0));
    end
  end

  for (genvar k = 0; k < CS; k++) begin : g_vcordic
    ptrib_cordic_cell #(.STEP(k)) u_cell (
      .clk_i   (clk_i),
      .en_i    (adv),
      .state_i (vc[k]),
      .state_o (vc[k+1])
    );
  end

  // ---------------------------------------------------------------- binning
  // bin = floor((2*(angle - min) + step) / (2*step))
  logic signed [ptrib_pkg::AW-1:0] vang_q, hang_a_q;
  logic signed [ptrib_pkg::NW-1:0] nv, nh;
  ptrib_pkg::div_t dv [QS+1];
  ptrib_pkg::div_t dh [QS+1];

  assign nv = ((ptrib_pkg::NW'(vang_q) - ptrib_pkg::NW'(vmin_q)) <<< 1)
              + $signed(ptrib_pkg::NW'(vstep_q));
  assign nh = ((ptrib_pkg::NW'(hang_a_q) - ptrib_pkg::NW'(hmin_q)) <<< 1)
              + $signed(ptrib_pkg::NW'(hstep_q));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vang_q   <= ptrib_pkg::angle_round(vc[CS]);
      hang_a_q <= hang_d;
      dv[0]    <= '{num: nv[QS-1:0], rem: '0, q: '0,
                    ok: (vstep_q != '0) && !nv[ptrib_pkg::NW-1]};
      dh[0]    <= '{num: nh[QS-1:0], rem: '0, q: '0,
                    ok: (hstep_q != '0) && !nh[ptrib_pkg::NW-1]};
    end
  end

  for (genvar k = 0; k < QS; k++) begin : g_div
    ptrib_div_cell u_vcell (
      .clk_i     (clk_i),
      .en_i      (adv),
      .divisor_i ({vstep_q, 1'b0}),
      .state_i   (dv[k]),
      .state_o   (dv[k+1])
    );
    ptrib_div_cell u_hcell (
      .clk_i     (clk_i),
      .en_i      (adv),
      .divisor_i ({hstep_q, 1'b0}),
      .state_i   (dh[k]),
      .state_o   (dh[k+1])
    );
  end

  // ---------------------------------------------------------------- verdict
  logic              row_ok, col_ok, range_ok;
  logic [19:0]       prod;
  logic [20:0]       idx;
  ptrib_pkg::result_t fin_res;

  assign row_ok   = dv[QS].ok && (dv[QS].q < QS'(rows_cap));
  assign col_ok   = dh[QS].ok && (dh[QS].q < QS'(cols_cap));
  assign range_ok = (range_d >= rlow_q) && (range_d <= rhigh_q);
  assign prod     = 20'(dv[QS].q[7:0]) * 20'(cols_cap);
  assign idx      = 21'(prod) + 21'(dh[QS].q[11:0]);

  always_comb begin
    fin_res = '{write_cell: 1'b0, cell_index: '0, range_value: range_d,
                outcome: ptrib_pkg::OUTCOME_WRITTEN};
    if (!fin_d) begin
      fin_res.range_value = '0;
      fin_res.outcome     = ptrib_pkg::OUTCOME_NOT_FINITE;
    end else if (!(row_ok && col_ok)) begin
      fin_res.outcome = ptrib_pkg::OUTCOME_OFF_GRID;
    end else if (!range_ok) begin
      fin_res.outcome = ptrib_pkg::OUTCOME_RANGE;
    end else begin
      fin_res.write_cell = 1'b1;
      fin_res.cell_index = idx[17:0];
    end
  end

  // ---------------------------------------------------------------- output + skid
  ptrib_pkg::result_t res_q, skid_q;
  logic stalled, take_skid, load_res;

  assign stalled   = res_v_q && !result_o.ready;
  assign take_skid = stalled && adv && v_q[ST_LAST-1];
  assign load_res  = !stalled;

  always_comb begin
    skid_v_d = skid_v_q;
    res_v_d  = res_v_q;
    if (stalled) begin
      if (take_skid) begin
        skid_v_d = 1'b1;
      end
    end else if (skid_v_q) begin
      res_v_d  = 1'b1;
      skid_v_d = 1'b0;
    end else begin
      res_v_d = v_q[ST_LAST-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
      res_v_q  <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_skid) begin
      skid_q <= fin_res;
    end
    if (load_res) begin
      res_q <= skid_v_q ? skid_q : fin_res;
    end
  end

  assign result_o.valid       = res_v_q;
  assign result_o.write_cell  = res_q.write_cell;
  assign result_o.cell_index  = res_q.cell_index;
  assign result_o.range_value = res_q.range_value;
  assign result_o.outcome     = res_q.outcome;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> res_v_q)
    else $error("skid holds a beat while the output register is empty");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !result_o.ready) |=> skid_v_q)
    else $error("skid beat lost while the output is stalled");

  a_write_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q |-> (res_q.write_cell == (res_q.outcome == ptrib_pkg::OUTCOME_WRITTEN)))
    else $error("write_cell disagrees with outcome");

  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v_q && !res_q.write_cell) |-> (res_q.cell_index == '0))
    else $error("cell_index set on a rejected point");
`endif

endmodule
